[rtl/core/tac_pkg.sv]
// Shared constants, register codes and pipeline payload types for the touch
// affine calibration core. No dependencies.
package tac_pkg;

  localparam int PANEL_WIDTH  = 1024;
  localparam int PANEL_HEIGHT = 600;

  localparam int RAW_W    = 16;
  localparam int COEF_W   = 32;
  localparam int SCREEN_W = 10;

  // signed coef times zero-extended raw value
  localparam int PROD_W = COEF_W + RAW_W + 1;
  // two products plus an offset, with headroom
  localparam int NUM_W  = PROD_W + 2;
  localparam int MAG_W  = NUM_W;

  localparam int PANEL_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  // quotient bits needed below the saturation limit
  localparam int QB = (PANEL_MAX > 1) ? $clog2(PANEL_MAX) : 1;

  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = ((2 * RAW_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * SCREEN_W + 7) / 8) * 8;

  localparam logic [SCREEN_W-1:0] X_MAX = SCREEN_W'(PANEL_WIDTH - 1);
  localparam logic [SCREEN_W-1:0] Y_MAX = SCREEN_W'(PANEL_HEIGHT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX = 3'd0,
    REG_COEF_XY = 3'd1,
    REG_OFFS_X  = 3'd2,
    REG_COEF_YX = 3'd3,
    REG_COEF_YY = 3'd4,
    REG_OFFS_Y  = 3'd5,
    REG_DIVISOR = 3'd6
  } cfg_reg_t;

  // live configuration plus values derived from the divisor at write time
  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] offs_x;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] offs_y;
    logic        [COEF_W-1:0] div_abs;
    logic                     div_neg;
    logic                     div_zero;
    logic        [MAG_W-1:0]  lim_x;
    logic        [MAG_W-1:0]  lim_y;
  } cfg_t;

  // one axis in flight through the divider
  typedef struct packed {
    logic             neg;
    logic             sat;
    logic [MAG_W-1:0] rem;
    logic [QB-1:0]    q;
  } lane_t;

  typedef struct packed {
    lane_t ax;
    lane_t ay;
    logic  dzero;
  } div_item_t;

endpackage

[rtl/core/tac_cfg_regs.sv]
// Configuration register file with divisor-derived magnitude, sign and
// saturation limits. Depends on tac_pkg.
module tac_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tac_pkg::COEF_W-1:0]    cfg_data,
  output tac_pkg::cfg_t                 cfg
);
  import tac_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    logic [COEF_W-1:0] dabs;
    dabs    = cfg_data[COEF_W-1] ? (~cfg_data + 1'b1) : cfg_data;
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF_XX: cfg_nxt.coef_xx = cfg_data;
        REG_COEF_XY: cfg_nxt.coef_xy = cfg_data;
        REG_OFFS_X:  cfg_nxt.offs_x  = cfg_data;
        REG_COEF_YX: cfg_nxt.coef_yx = cfg_data;
        REG_COEF_YY: cfg_nxt.coef_yy = cfg_data;
        REG_OFFS_Y:  cfg_nxt.offs_y  = cfg_data;
        REG_DIVISOR: begin
          cfg_nxt.div_abs  = dabs;
          cfg_nxt.div_neg  = cfg_data[COEF_W-1];
          cfg_nxt.div_zero = (cfg_data == '0);
          cfg_nxt.lim_x    = MAG_W'(dabs) * MAG_W'(PANEL_WIDTH);
          cfg_nxt.lim_y    = MAG_W'(dabs) * MAG_W'(PANEL_HEIGHT);
        end
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_xx  <= COEF_W'(1);
      cfg_r.coef_xy  <= '0;
      cfg_r.offs_x   <= '0;
      cfg_r.coef_yx  <= '0;
      cfg_r.coef_yy  <= COEF_W'(1);
      cfg_r.offs_y   <= '0;
      cfg_r.div_abs  <= COEF_W'(1);
      cfg_r.div_neg  <= 1'b0;
      cfg_r.div_zero <= 1'b0;
      cfg_r.lim_x    <= MAG_W'(PANEL_WIDTH);
      cfg_r.lim_y    <= MAG_W'(PANEL_HEIGHT);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/tac_numer.sv]
// Three-stage numerator front end: products, sums, then sign/magnitude and
// saturation classification for both axes. Depends on tac_pkg.
module tac_numer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tac_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tac_pkg::RAW_W-1:0] raw_x,
  input  logic [tac_pkg::RAW_W-1:0] raw_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tac_pkg::div_item_t        out_item
);
  import tac_pkg::*;

  logic s1_v_r, s2_v_r, s3_v_r;
  logic en1, en2, en3;

  logic signed [PROD_W-1:0] pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [PROD_W-1:0] pxx_nxt, pxy_nxt, pyx_nxt, pyy_nxt;
  logic signed [NUM_W-1:0]  num_x_r, num_y_r, num_x_nxt, num_y_nxt;
  div_item_t                item_r, item_nxt;

  logic signed [RAW_W:0] rx_s, ry_s;

  // stage moves when empty or when its content moves on
  assign en3      = !s3_v_r || out_ready;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  assign rx_s = $signed({1'b0, raw_x});
  assign ry_s = $signed({1'b0, raw_y});

  assign pxx_nxt = $signed(cfg.coef_xx) * rx_s;
  assign pxy_nxt = $signed(cfg.coef_xy) * ry_s;
  assign pyx_nxt = $signed(cfg.coef_yx) * rx_s;
  assign pyy_nxt = $signed(cfg.coef_yy) * ry_s;

  assign num_x_nxt = pxx_r + pxy_r + $signed(cfg.offs_x);
  assign num_y_nxt = pyx_r + pyy_r + $signed(cfg.offs_y);

  always_comb begin
    logic [MAG_W-1:0] mag_x, mag_y;
    mag_x = num_x_r[NUM_W-1] ? MAG_W'(-num_x_r) : MAG_W'(num_x_r);
    mag_y = num_y_r[NUM_W-1] ? MAG_W'(-num_y_r) : MAG_W'(num_y_r);
    item_nxt.dzero  = cfg.div_zero;
    // opposite signs: truncated quotient is zero or negative, clamps to zero
    item_nxt.ax.neg = num_x_r[NUM_W-1] ^ cfg.div_neg;
    item_nxt.ax.sat = mag_x >= cfg.lim_x;
    item_nxt.ax.rem = mag_x;
    item_nxt.ax.q   = '0;
    item_nxt.ay.neg = num_y_r[NUM_W-1] ^ cfg.div_neg;
    item_nxt.ay.sat = mag_y >= cfg.lim_y;
    item_nxt.ay.rem = mag_y;
    item_nxt.ay.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      pxx_r <= pxx_nxt;
      pxy_r <= pxy_nxt;
      pyx_r <= pyx_nxt;
      pyy_r <= pyy_nxt;
    end
    if (en2 && s1_v_r) begin
      num_x_r <= num_x_nxt;
      num_y_r <= num_y_nxt;
    end
    if (en3 && s2_v_r) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_item  = item_r;

endmodule

[rtl/core/tac_div_pipe.sv]
// Restoring divider, one quotient bit per register stage, two axis lanes
// sharing the divisor magnitude. Depends on tac_pkg.
module tac_div_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  tac_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  tac_pkg::div_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output tac_pkg::div_item_t out_item
);
  import tac_pkg::*;

  logic [QB-1:0] vld_r;
  div_item_t     stg_r   [QB];
  div_item_t     stg_nxt [QB];
  logic [QB-1:0] rdy;

  function automatic lane_t div_step(lane_t l, logic [MAG_W-1:0] trial, int k);
    lane_t o;
    o = l;
    if (l.rem >= trial) begin
      o.rem  = l.rem - trial;
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

  // bit QB-1-s is resolved in stage s
  always_comb begin
    div_item_t        src;
    logic [MAG_W-1:0] trial;
    for (int s = 0; s < QB; s++) begin
      if (s == 0) src = in_item;
      else        src = stg_r[(s == 0) ? 0 : s - 1];
      trial          = MAG_W'(cfg.div_abs) << (QB - 1 - s);
      stg_nxt[s]     = src;
      stg_nxt[s].ax  = div_step(src.ax, trial, QB - 1 - s);
      stg_nxt[s].ay  = div_step(src.ay, trial, QB - 1 - s);
    end
  end

  always_comb begin
    rdy[QB-1] = !vld_r[QB-1] || out_ready;
    for (int s = QB - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int s = 0; s < QB; s++) begin
        if (rdy[s]) vld_r[s] <= (s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QB; s++) begin
      if (rdy[s] && ((s == 0) ? in_valid : vld_r[(s == 0) ? 0 : s - 1])) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[QB-1];
  assign out_item  = stg_r[QB-1];

endmodule

[rtl/core/touch_affine_calibration.sv]
// Pipeline: products, sums, sign/limit, one divider stage per quotient bit,
//   then the clamped output register.
// Throughput: one sample per cycle unless out_tready stalls; each stage holds its item under stall.
// Reset: rst_n (sync, active low) empties the pipeline and loads the
//   identity mapping (x -> x, y -> y, divisor 1).
module touch_affine_calibration (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tac_pkg::IN_TDATA_W-1:0]  in_tdata,   // raw_x [15:0], raw_y [31:16]
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tac_pkg::OUT_TDATA_W-1:0] out_tdata,  // screen_x [9:0], screen_y [19:10], zero pad
  output logic [0:0]                      out_tuser,  // divide_error [0]
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tac_pkg::COEF_W-1:0]      cfg_data
);
  import tac_pkg::*;

  cfg_t      cfg;
  logic      num_valid, num_ready;
  div_item_t num_item;
  logic      div_valid, div_ready;
  div_item_t div_item;

  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_err_r;
  logic                   en_out;

  tac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // front end: a*x + b*y + c per axis, then sign and saturation check
  tac_numer u_numer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .raw_x     (in_tdata[RAW_W-1:0]),
    .raw_y     (in_tdata[2*RAW_W-1:RAW_W]),
    .out_valid (num_valid),
    .out_ready (num_ready),
    .out_item  (num_item)
  );

  // magnitude quotient, only needed below the panel-size limit
  tac_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (num_valid),
    .in_ready  (num_ready),
    .in_item   (num_item),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  // output register decouples the result side from the pipe
  assign en_out    = !out_v_r || out_tready;
  assign div_ready = en_out;

  always_comb begin
    logic [SCREEN_W-1:0] sx, sy;
    priority if (div_item.dzero || div_item.ax.neg) sx = '0;
    else if (div_item.ax.sat)                       sx = X_MAX;
    else                                            sx = SCREEN_W'(div_item.ax.q);
    priority if (div_item.dzero || div_item.ay.neg) sy = '0;
    else if (div_item.ay.sat)                       sy = Y_MAX;
    else                                            sy = SCREEN_W'(div_item.ay.q);
    out_data_nxt = OUT_TDATA_W'({sy, sx});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_out) begin
      out_v_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && div_valid) begin
      out_data_r <= out_data_nxt;
      out_err_r  <= div_item.dzero;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;

`ifndef ASSERT_OFF
  // divide error always comes with zero coordinates
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("divide error with nonzero coordinates");

  // coordinates stay inside the panel
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[SCREEN_W-1:0] <= X_MAX) &&
                    (out_tdata[2*SCREEN_W-1:SCREEN_W] <= Y_MAX)))
    else $error("screen coordinate beyond panel");

  // input only backs up when the whole pipe is full and the result waits
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

  // derived divisor flags agree with the stored magnitude
  a_div_flags: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.div_zero == (cfg.div_abs == '0))
    else $error("divisor zero flag out of step");
`endif

endmodule
